// ===== rtl/core/btgr_pkg.sv =====
// ============================================================================
// btgr_pkg
// Shared types, codes and constants of the bitmap text glyph renderer.
// ============================================================================
`default_nettype none

package btgr_pkg;

   // Port widths.
   localparam int REQ_DATA_W   = 56;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 40;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // Field widths.
   localparam int COLOUR_W     = 16;
   localparam int PIX_OUT_W    = 17;
   localparam int CHAR_W       = 8;
   localparam int START_X_W    = 9;
   localparam int ROW_W        = 9;
   localparam int FONT_INDEX_W = 13;
   localparam int GLYPH_CODE_W = 7;
   localparam int SIZE_REG_W   = 4;
   // A drawn column is always below the screen width; 10 bits fit up to 1024.
   localparam int SCREEN_COL_W = 10;

   // Parameter defaults.
   localparam int DEF_SCREEN_WIDTH = 320;
   localparam int DEF_GLYPH_COUNT  = 95;
   localparam int DEF_MAX_GLYPH_W  = 8;
   localparam int DEF_MAX_GLYPH_H  = 8;
   localparam int DEF_STRING_LIMIT = 256;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [COLOUR_W-1:0] KEY_COLOUR = 16'hF81F;
   localparam int                  ROW_LIMIT  = 383;
   localparam logic [ROW_W-1:0]    ROW_MAX    = 9'd383;
   localparam logic [CHAR_W-1:0]   CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0]   CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0]   FIRST_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0]   LAST_CHAR    = 8'h7E;

   // Register reset values.
   localparam logic [COLOUR_W-1:0]   FG_RESET     = 16'hFFFF;
   localparam logic [COLOUR_W-1:0]   BG_RESET     = 16'h0000;
   localparam logic [SIZE_REG_W-1:0] GLYPH_W_RESET = 4'd8;
   localparam logic [SIZE_REG_W-1:0] GLYPH_H_RESET = 4'd8;

   typedef enum logic [REQ_USER_W-1:0] {
      MODE_LOAD  = 2'd0,
      MODE_START = 2'd1,
      MODE_CHAR  = 2'd2
   } btgr_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FG_COLOUR    = 3'd0,
      REG_BG_COLOUR    = 3'd1,
      REG_FILL_BG      = 3'd2,
      REG_GLYPH_WIDTH  = 3'd3,
      REG_GLYPH_HEIGHT = 3'd4
   } btgr_reg_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_GLYPH = 1'b1
   } btgr_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DRAW = 1'b1
   } btgr_state_type;

   // One unit of work handed from the front end to the drawing unit.
   typedef struct packed {
      btgr_kind_type               kind;
      logic [FONT_INDEX_W-1:0]     font_index;
      logic                        opaque;
      logic [GLYPH_CODE_W-1:0]     glyph;
      logic [SCREEN_COL_W-1:0]     col;
      logic [ROW_W-1:0]            row;
   } btgr_item_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] fg;
      logic [COLOUR_W-1:0] bg;
      logic                fill;
   } btgr_style_type;

endpackage

`default_nettype wire

// ===== rtl/core/btgr_front.sv =====
// ============================================================================
// btgr_front
// Accepts request items, keeps the cursor and string state, and queues font
// writes and glyph draws for the drawing unit.
// ============================================================================
`default_nettype none

module btgr_front #(
   parameter int SCREEN_WIDTH = btgr_pkg::DEF_SCREEN_WIDTH,
   parameter int GLYPH_COUNT  = btgr_pkg::DEF_GLYPH_COUNT,
   parameter int MAX_GLYPH_W  = btgr_pkg::DEF_MAX_GLYPH_W,
   parameter int MAX_GLYPH_H  = btgr_pkg::DEF_MAX_GLYPH_H,
   parameter int STRING_LIMIT = btgr_pkg::DEF_STRING_LIMIT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [btgr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [btgr_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic [$clog2(MAX_GLYPH_W+1)-1:0]     glyph_w,
   input  logic [$clog2(MAX_GLYPH_H+1)-1:0]     glyph_h,
   output logic                                 push,
   output btgr_pkg::btgr_item_type              push_item,
   input  logic                                 queue_full
);

   localparam int COL_W = $clog2((SCREEN_WIDTH + MAX_GLYPH_W > 512) ?
                                 SCREEN_WIDTH + MAX_GLYPH_W : 512);
   localparam int CNT_W      = $clog2(STRING_LIMIT + 1);
   localparam int MASK_DEPTH = GLYPH_COUNT * MAX_GLYPH_W * MAX_GLYPH_H;

   logic [btgr_pkg::CHAR_W-1:0]       char_code;
   logic [btgr_pkg::START_X_W-1:0]    start_x;
   logic [btgr_pkg::ROW_W-1:0]        start_y;
   logic [btgr_pkg::FONT_INDEX_W-1:0] font_index;
   logic [btgr_pkg::COLOUR_W-1:0]     font_pixel;
   btgr_pkg::btgr_mode_type           mode;
   logic                              accept;

   logic [COL_W-1:0]                  cursor_col_ff, cursor_col_in;
   logic [btgr_pkg::ROW_W-1:0]        cursor_row_ff, cursor_row_in;
   logic [btgr_pkg::START_X_W-1:0]    origin_col_ff, origin_col_in;
   logic [CNT_W-1:0]                  chars_seen_ff, chars_seen_in;
   logic                              string_done_ff, string_done_in;

   logic [btgr_pkg::ROW_W:0]          row_sum;
   logic [COL_W-1:0]                  col_sum;

   assign char_code  = req_tdata[7:0];
   assign start_x    = req_tdata[16:8];
   assign start_y    = req_tdata[25:17];
   assign font_index = req_tdata[38:26];
   assign font_pixel = req_tdata[54:39];
   assign mode       = btgr_pkg::btgr_mode_type'(req_tuser);

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign row_sum = (btgr_pkg::ROW_W+1)'(cursor_row_ff) + (btgr_pkg::ROW_W+1)'(glyph_h);
   assign col_sum = cursor_col_ff + COL_W'(glyph_w);

   always_comb begin
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      origin_col_in  = origin_col_ff;
      chars_seen_in  = chars_seen_ff;
      string_done_in = string_done_ff;
      push           = 1'b0;

      push_item.kind       = btgr_pkg::KIND_GLYPH;
      push_item.font_index = font_index;
      push_item.opaque     = (font_pixel != btgr_pkg::KEY_COLOUR);
      push_item.glyph      = btgr_pkg::GLYPH_CODE_W'(char_code - btgr_pkg::FIRST_CHAR);
      push_item.col        = btgr_pkg::SCREEN_COL_W'(cursor_col_ff);
      push_item.row        = cursor_row_ff;

      if (accept) begin
         unique case (mode)
            btgr_pkg::MODE_LOAD: begin
               if (32'(font_index) < MASK_DEPTH) begin
                  push           = 1'b1;
                  push_item.kind = btgr_pkg::KIND_LOAD;
               end
            end
            btgr_pkg::MODE_START: begin
               origin_col_in  = start_x;
               cursor_col_in  = COL_W'(start_x);
               cursor_row_in  = (start_y > btgr_pkg::ROW_MAX) ? btgr_pkg::ROW_MAX : start_y;
               chars_seen_in  = '0;
               string_done_in = 1'b0;
            end
            btgr_pkg::MODE_CHAR: begin
               if (!string_done_ff) begin
                  if (32'(chars_seen_ff) >= STRING_LIMIT) begin
                     string_done_in = 1'b1;
                  end else begin
                     chars_seen_in = chars_seen_ff + CNT_W'(1);
                     if (char_code == btgr_pkg::CHAR_NUL) begin
                        string_done_in = 1'b1;
                     end else if (32'(cursor_col_ff) < SCREEN_WIDTH) begin
                        // Past the right edge every char but NUL is dropped.
                        if (char_code == btgr_pkg::CHAR_NEWLINE) begin
                           cursor_row_in = (row_sum > (btgr_pkg::ROW_W+1)'(btgr_pkg::ROW_MAX)) ?
                                           btgr_pkg::ROW_MAX : btgr_pkg::ROW_W'(row_sum);
                           cursor_col_in = COL_W'(origin_col_ff);
                        end else begin
                           if (char_code >= btgr_pkg::FIRST_CHAR &&
                               char_code <= btgr_pkg::LAST_CHAR) begin
                              push = 1'b1;
                           end
                           cursor_col_in = col_sum;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         origin_col_ff  <= '0;
         chars_seen_ff  <= '0;
         string_done_ff <= 1'b1;
      end else begin
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         origin_col_ff  <= origin_col_in;
         chars_seen_ff  <= chars_seen_in;
         string_done_ff <= string_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/btgr_queue.sv =====
// ============================================================================
// btgr_queue
// Small FIFO of work items between the front end and the drawing unit.
// ============================================================================
`default_nettype none

module btgr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  btgr_pkg::btgr_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output btgr_pkg::btgr_item_type head,
   output logic                    empty
);

   localparam int DEPTH = btgr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   btgr_pkg::btgr_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/btgr_back.sv =====
// ============================================================================
// btgr_back
// Drawing unit: owns the glyph mask store, walks each glyph one pixel per
// cycle unless stalled, emits pixel writes and marks each character's last.
// ============================================================================
`default_nettype none

module btgr_back #(
   parameter int SCREEN_WIDTH = btgr_pkg::DEF_SCREEN_WIDTH,
   parameter int GLYPH_COUNT  = btgr_pkg::DEF_GLYPH_COUNT,
   parameter int MAX_GLYPH_W  = btgr_pkg::DEF_MAX_GLYPH_W,
   parameter int MAX_GLYPH_H  = btgr_pkg::DEF_MAX_GLYPH_H
) (
   input  logic                              clock,
   input  logic                              reset,
   output logic                              pop,
   input  btgr_pkg::btgr_item_type           head,
   input  logic                              empty,
   input  logic [$clog2(MAX_GLYPH_W+1)-1:0]  glyph_w,
   input  logic [$clog2(MAX_GLYPH_H+1)-1:0]  glyph_h,
   input  btgr_pkg::btgr_style_type          style,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [btgr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int GW_W       = $clog2(MAX_GLYPH_W + 1);
   localparam int GH_W       = $clog2(MAX_GLYPH_H + 1);
   localparam int MASK_DEPTH = GLYPH_COUNT * MAX_GLYPH_W * MAX_GLYPH_H;
   localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
   localparam int IDX_MAX    = int'(btgr_pkg::LAST_CHAR - btgr_pkg::FIRST_CHAR) * MAX_GLYPH_W
                               + (MAX_GLYPH_H - 1) * GLYPH_COUNT * MAX_GLYPH_W
                               + MAX_GLYPH_W - 1;
   localparam int IDX_W      = $clog2(IDX_MAX + 1);
   localparam int CI_W       = $clog2(SCREEN_WIDTH + MAX_GLYPH_W);
   localparam int PIX_W      = $clog2((btgr_pkg::ROW_LIMIT + MAX_GLYPH_H) * SCREEN_WIDTH);
   localparam int PAD_W      = btgr_pkg::RSP_DATA_W - btgr_pkg::PIX_OUT_W - btgr_pkg::COLOUR_W;

   btgr_pkg::btgr_state_type state_ff, state_in;

   logic                       mask_mem [MASK_DEPTH];
   logic                       mask_q_ff;

   // Glyph walk.
   logic [GW_W-1:0]            i_ff;
   logic [GH_W-1:0]            j_ff;
   logic [CI_W-1:0]            col0_ff, col_i_ff;
   logic [PIX_W-1:0]           line_pix_ff;
   logic [IDX_W-1:0]           mask_row_ff;

   // Stage after the mask read.
   logic                       b_valid_ff, b_final_ff, b_visible_ff, b_inrange_ff;
   logic [PIX_W-1:0]           b_pix_ff;

   // One write held back until it is known whether it ends the character.
   logic                       pend_valid_ff, pend_last_ff;
   logic [PIX_W-1:0]           pend_pix_ff;
   logic [btgr_pkg::COLOUR_W-1:0] pend_colour_ff;

   logic                       out_valid_ff, out_last_ff;
   logic [PIX_W-1:0]           out_pix_ff;
   logic [btgr_pkg::COLOUR_W-1:0] out_colour_ff;

   logic                       en, step, start_glyph, load_font;
   logic [IDX_W-1:0]           addr, row_stride;
   logic                       in_range, visible, row_end, glyph_end;
   logic                       opaque, emit, take;

   assign en          = !out_valid_ff || rsp_tready;
   assign step        = (state_ff == btgr_pkg::ST_DRAW) && en;
   assign start_glyph = pop && (head.kind == btgr_pkg::KIND_GLYPH);
   assign load_font   = pop && (head.kind == btgr_pkg::KIND_LOAD);

   assign addr       = mask_row_ff + IDX_W'(i_ff);
   assign row_stride = IDX_W'(GLYPH_COUNT) * IDX_W'(glyph_w);
   assign in_range   = 32'(addr) < MASK_DEPTH;
   assign visible    = 32'(col_i_ff) < SCREEN_WIDTH;
   assign row_end    = (i_ff == GW_W'(glyph_w - GW_W'(1)));
   assign glyph_end  = row_end && (j_ff == GH_W'(glyph_h - GH_W'(1)));

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         btgr_pkg::ST_IDLE: begin
            pop = !empty;
            if (!empty && head.kind == btgr_pkg::KIND_GLYPH) begin
               state_in = btgr_pkg::ST_DRAW;
            end
         end
         btgr_pkg::ST_DRAW: begin
            if (step && glyph_end) begin
               state_in = btgr_pkg::ST_IDLE;
            end
         end
         default: state_in = btgr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Font writes only happen between glyphs, so reads see them in order.
   always_ff @(posedge clock) begin
      if (load_font) begin
         mask_mem[MASK_AW'(head.font_index)] <= head.opaque;
      end
      if (step && in_range) begin
         mask_q_ff <= mask_mem[MASK_AW'(addr)];
      end
   end

   always_ff @(posedge clock) begin
      if (start_glyph) begin
         i_ff        <= '0;
         j_ff        <= '0;
         col0_ff     <= CI_W'(head.col);
         col_i_ff    <= CI_W'(head.col);
         line_pix_ff <= PIX_W'(head.col) + PIX_W'(head.row) * PIX_W'(SCREEN_WIDTH);
         mask_row_ff <= IDX_W'(head.glyph) * IDX_W'(glyph_w);
      end else if (step) begin
         if (row_end) begin
            i_ff        <= '0;
            j_ff        <= j_ff + GH_W'(1);
            col_i_ff    <= col0_ff;
            line_pix_ff <= line_pix_ff + PIX_W'(SCREEN_WIDTH);
            mask_row_ff <= mask_row_ff + row_stride;
         end else begin
            i_ff     <= i_ff + GW_W'(1);
            col_i_ff <= col_i_ff + CI_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_final_ff   <= glyph_end;
         b_visible_ff <= visible;
         b_inrange_ff <= in_range;
         b_pix_ff     <= line_pix_ff + PIX_W'(i_ff);
      end
   end

   assign opaque = b_inrange_ff && mask_q_ff;
   assign emit   = b_valid_ff && b_visible_ff && (opaque || style.fill);
   assign take   = pend_valid_ff && (pend_last_ff || emit || (b_valid_ff && b_final_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         b_valid_ff    <= (state_ff == btgr_pkg::ST_DRAW);
         pend_valid_ff <= emit || (pend_valid_ff && !take);
         out_valid_ff  <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (en && take) begin
         out_pix_ff    <= pend_pix_ff;
         out_colour_ff <= pend_colour_ff;
         out_last_ff   <= pend_last_ff || (b_valid_ff && b_final_ff && !emit);
      end
      if (en && emit) begin
         pend_pix_ff    <= b_pix_ff;
         pend_colour_ff <= opaque ? style.fg : style.bg;
         pend_last_ff   <= b_final_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {PAD_W'(0), out_colour_ff, btgr_pkg::PIX_OUT_W'(out_pix_ff)};

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_text_glyph_renderer.sv =====
// ============================================================================
// bitmap_text_glyph_renderer
// Turns character items into framebuffer pixel writes from a loaded font mask.
// ============================================================================
// Font-load, start and non-drawing character items do not enter the glyph walk; a printable
// character holds the drawing unit for its whole walk, one mask read per pixel. A write
// waits for the next write or the glyph end, so the first is offered only after the queue,
// the walk, the mask-read stage and the held write. Items queue two deep; requests stall
// only while it is full. Synchronous reset clears cursor and string state (no string
// active), the queue, the pipeline and the registers; the font store is not cleared.
`default_nettype none

module bitmap_text_glyph_renderer #(
   parameter int SCREEN_WIDTH = btgr_pkg::DEF_SCREEN_WIDTH,
   parameter int GLYPH_COUNT  = btgr_pkg::DEF_GLYPH_COUNT,
   parameter int MAX_GLYPH_W  = btgr_pkg::DEF_MAX_GLYPH_W,
   parameter int MAX_GLYPH_H  = btgr_pkg::DEF_MAX_GLYPH_H,
   parameter int STRING_LIMIT = btgr_pkg::DEF_STRING_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // char_code[7:0], start_x[16:8], start_y[25:17], font_index[38:26],
   // font_pixel[54:39], zero[55]
   input  logic [btgr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[1:0]
   input  logic [btgr_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_index[16:0], pixel_colour[32:17], zero[39:33]
   output logic [btgr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [btgr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [btgr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int GW_W = $clog2(MAX_GLYPH_W + 1);
   localparam int GH_W = $clog2(MAX_GLYPH_H + 1);

   logic [btgr_pkg::COLOUR_W-1:0]   fg_colour_ff, bg_colour_ff;
   logic                            fill_bg_ff;
   logic [btgr_pkg::SIZE_REG_W-1:0] glyph_width_ff, glyph_height_ff;

   logic [GW_W-1:0]                 glyph_w;
   logic [GH_W-1:0]                 glyph_h;
   btgr_pkg::btgr_style_type        style;

   logic                            push, queue_full, pop, empty;
   btgr_pkg::btgr_item_type         push_item, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_colour_ff    <= btgr_pkg::FG_RESET;
         bg_colour_ff    <= btgr_pkg::BG_RESET;
         fill_bg_ff      <= 1'b0;
         glyph_width_ff  <= btgr_pkg::GLYPH_W_RESET;
         glyph_height_ff <= btgr_pkg::GLYPH_H_RESET;
      end else if (csr_we) begin
         unique case (btgr_pkg::btgr_reg_type'(csr_index))
            btgr_pkg::REG_FG_COLOUR:    fg_colour_ff    <= csr_wdata;
            btgr_pkg::REG_BG_COLOUR:    bg_colour_ff    <= csr_wdata;
            btgr_pkg::REG_FILL_BG:      fill_bg_ff      <= csr_wdata[0];
            btgr_pkg::REG_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata[btgr_pkg::SIZE_REG_W-1:0];
            btgr_pkg::REG_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[btgr_pkg::SIZE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero draws as one, anything above the maximum as the maximum.
   always_comb begin
      if (glyph_width_ff == '0) begin
         glyph_w = GW_W'(1);
      end else if (32'(glyph_width_ff) > MAX_GLYPH_W) begin
         glyph_w = GW_W'(MAX_GLYPH_W);
      end else begin
         glyph_w = GW_W'(glyph_width_ff);
      end
      if (glyph_height_ff == '0) begin
         glyph_h = GH_W'(1);
      end else if (32'(glyph_height_ff) > MAX_GLYPH_H) begin
         glyph_h = GH_W'(MAX_GLYPH_H);
      end else begin
         glyph_h = GH_W'(glyph_height_ff);
      end
   end

   assign style.fg   = fg_colour_ff;
   assign style.bg   = bg_colour_ff;
   assign style.fill = fill_bg_ff;

   btgr_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .GLYPH_COUNT  (GLYPH_COUNT),
      .MAX_GLYPH_W  (MAX_GLYPH_W),
      .MAX_GLYPH_H  (MAX_GLYPH_H),
      .STRING_LIMIT (STRING_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .glyph_w    (glyph_w),
      .glyph_h    (glyph_h),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   btgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   btgr_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .GLYPH_COUNT  (GLYPH_COUNT),
      .MAX_GLYPH_W  (MAX_GLYPH_W),
      .MAX_GLYPH_H  (MAX_GLYPH_H)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .glyph_w    (glyph_w),
      .glyph_h    (glyph_h),
      .style      (style),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/btgr_checker.sv =====
// ============================================================================
// btgr_checker
// Port-level checks on the renderer's handshakes and pixel writes.
// ============================================================================
`default_nettype none

module btgr_checker #(
   parameter int SCREEN_WIDTH = btgr_pkg::DEF_SCREEN_WIDTH,
   parameter int MAX_GLYPH_H  = btgr_pkg::DEF_MAX_GLYPH_H
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [btgr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast
);

   localparam int PIX_BOUND = (btgr_pkg::ROW_LIMIT + MAX_GLYPH_H) * SCREEN_WIDTH;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result transfer changed while stalled");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline or queue not empty after reset");

   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[btgr_pkg::PIX_OUT_W-1:0]) < PIX_BOUND)
      else $error("pixel write below the lowest reachable row");

endmodule

bind bitmap_text_glyph_renderer btgr_checker #(
   .SCREEN_WIDTH (SCREEN_WIDTH),
   .MAX_GLYPH_H  (MAX_GLYPH_H)
) u_btgr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
